FILE: hw/rtl/hmp_pkg.sv
// Package for the hash message padder: item types, register indexes and
// padding constants. No dependencies.
`default_nettype none

package hmp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [63:0] padded_word;
    logic        last_word;
  } out_item_t;

  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_LENGTH_BIG_ENDIAN = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WIDE_LENGTH_FIELD = 2'd1;

  localparam logic [7:0] PAD_MARK     = 8'h80;
  localparam logic [5:0] TARGET_NARROW = 6'd56;
  localparam logic [5:0] TARGET_WIDE   = 6'd32;
  localparam logic [5:0] LEN_START     = 6'd56;
  localparam logic [5:0] BLOCK_END     = 6'd63;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_PAD  = 2'b10
  } state_e;

endpackage

`default_nettype wire

FILE: hw/rtl/hash_message_padder_unit.sv
// Output: a byte that completes a word shows that word in the cycle after its item is accepted.
// Throughput: one message byte per cycle while the output is not stalled; an end-of-message item
// then holds the input while the tail sequencer emits the mark byte, the zero bytes and the length
// field, one padding byte per cycle while the output is not stalled. Output stalls stop the byte shifter in place.
// Reset: asynchronous, active low; clears count, sequencer and output valid, loads defaults
// (big-endian length, 8-byte length field).
`default_nettype none

module hash_message_padder_unit
  import hmp_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 61
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire in_item_t           in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output out_item_t               out_item_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic               cfg_data_i
);

  state_e                  state_q, state_d;
  logic [COUNT_BITS-1:0]   count_q, count_d, count_inc;
  logic [5:0]              pos_q, pos_d, pos_next;
  logic [55:0]             acc_q, acc_d;
  logic [63:0]             len_sr_q, len_sr_d;
  logic                    mark_q, mark_d;
  logic                    wrap_q, wrap_d;
  logic                    len_q, len_d;
  logic                    be_q, wide_q;
  logic                    out_valid_q, out_valid_d;
  out_item_t               out_q, out_d;
  logic                    out_free, put, last, wrap_keep;
  logic [7:0]              put_byte;
  logic [5:0]              target;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !((state_q == ST_IDLE) && out_free);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign cfg_ready_o = 1'b1;
  assign target      = wide_q ? TARGET_WIDE : TARGET_NARROW;
  assign pos_next    = pos_q + 6'd1;
  assign wrap_keep   = wrap_q && (pos_next != 6'd0);
  assign count_inc   = in_item_i.byte_valid ? count_q + COUNT_BITS'(1) : count_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    acc_d       = acc_q;
    len_sr_d    = len_sr_q;
    mark_d      = mark_q;
    wrap_d      = wrap_q;
    len_d       = len_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    put         = 1'b0;
    put_byte    = 8'd0;
    last        = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && !in_stall_o) begin
          if (in_item_i.byte_valid) begin
            put      = 1'b1;
            put_byte = in_item_i.data_byte;
            count_d  = count_inc;
            pos_d    = pos_next;
          end
          if (in_item_i.end_of_message) begin
            state_d  = ST_PAD;
            mark_d   = 1'b1;
            wrap_d   = 1'b0;
            len_d    = 1'b0;
            len_sr_d = 64'(count_inc) << 3;
          end
        end
      end
      ST_PAD: begin
        if (out_free) begin
          put   = 1'b1;
          pos_d = pos_next;
          if (mark_q) begin
            put_byte = PAD_MARK;
            mark_d   = 1'b0;
            wrap_d   = pos_next > target;
            len_d    = pos_next == target;
          end else if (len_q) begin
            if (pos_q >= LEN_START) begin
              put_byte = be_q ? len_sr_q[63:56] : len_sr_q[7:0];
              len_sr_d = be_q ? {len_sr_q[55:0], 8'd0} : {8'd0, len_sr_q[63:8]};
            end
            if (pos_q == BLOCK_END) begin
              last    = 1'b1;
              state_d = ST_IDLE;
              count_d = '0;
              len_d   = 1'b0;
            end
          end else begin
            wrap_d = wrap_keep;
            len_d  = (pos_next == target) && !wrap_keep;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (put) begin
      acc_d = {acc_q[47:0], put_byte};
      if (pos_q[2:0] == 3'd7) begin
        out_valid_d       = 1'b1;
        out_d.padded_word = {acc_q, put_byte};
        out_d.last_word   = last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      pos_q       <= '0;
      mark_q      <= 1'b0;
      wrap_q      <= 1'b0;
      len_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pos_q       <= pos_d;
      mark_q      <= mark_d;
      wrap_q      <= wrap_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    len_sr_q <= len_sr_d;
    out_q    <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      be_q   <= 1'b1;
      wide_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_LENGTH_BIG_ENDIAN: be_q   <= cfg_data_i;
        CFG_WIDE_LENGTH_FIELD: wide_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> state_q == ST_IDLE)
    else $error("item taken outside idle");

  a_flags_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mark_q || wrap_q || len_q) |-> state_q == ST_PAD)
    else $error("padding flag set outside padding");

  a_wrap_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wrap_q && len_q) && !(mark_q && (wrap_q || len_q)))
    else $error("conflicting padding phases");

  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (put && last) |=> (state_q == ST_IDLE) && (pos_q == 6'd0) && (count_q == '0)
      && out_valid_q && out_q.last_word)
    else $error("final word did not close the message");

  a_word_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (put && (pos_q[2:0] == 3'd7)) |=> out_valid_q)
    else $error("completed word not presented");
`endif

endmodule

`default_nettype wire
